/* hdl/tlsa_pkg.sv */
package tlsa_pkg;

    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IMM_W    = 5;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned AMT_W    = 6;

    localparam logic [OPCODE_W-1:0] OP_AND     = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_BIC     = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_EOR     = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_ORR     = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_MVN     = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_ASR_IMM = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_ASR_REG = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_LSL_IMM = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_LSR_IMM = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_LSL_REG = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_LSR_REG = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_ROR_REG = 4'd11;

    // register counts of 33 and above all behave alike
    localparam logic [AMT_W-1:0] AMT_FULL = 6'd32;
    localparam logic [AMT_W-1:0] AMT_OVER = 6'd33;

    typedef struct packed {
        logic              flag_n;
        logic              flag_z;
        logic              flag_c;
    } t_flags;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_en;
        logic              update;
        logic              carry;
    } t_exec_res;

endpackage

/* hdl/tlsa_exec.sv */
module tlsa_exec
    import tlsa_pkg::*;
(
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [DATA_W-1:0]   i_dest_value,
    input  logic [DATA_W-1:0]   i_source_value,
    input  logic [IMM_W-1:0]    i_shift_imm,
    input  logic                i_carry,
    output t_exec_res           o_res
);

    logic               is_imm;
    logic [DATA_W-1:0]  shift_val;
    logic [7:0]         cnt;
    logic [AMT_W-1:0]   reg_amt;
    logic [AMT_W-1:0]   imm_amt;
    logic [AMT_W-1:0]   amt;
    logic [DATA_W:0]    lsl_ext;
    logic [DATA_W:0]    lsr_ext;
    logic signed [DATA_W:0] asr_ext;
    logic [2*DATA_W-1:0] ror_ext;
    logic               keep_c;

    assign is_imm    = (i_opcode == OP_ASR_IMM) || (i_opcode == OP_LSL_IMM)
                    || (i_opcode == OP_LSR_IMM);
    assign shift_val = is_imm ? i_source_value : i_dest_value;
    assign cnt       = i_source_value[7:0];
    assign reg_amt   = (cnt > 8'(AMT_FULL)) ? AMT_OVER : cnt[AMT_W-1:0];

    // zero immediate means 32 for the right shifts, not for lsl
    always_comb begin
        if (i_opcode == OP_LSL_IMM) begin
            imm_amt = {1'b0, i_shift_imm};
        end else if (i_shift_imm == '0) begin
            imm_amt = AMT_FULL;
        end else begin
            imm_amt = {1'b0, i_shift_imm};
        end
    end

    assign amt    = is_imm ? imm_amt : reg_amt;
    assign keep_c = (amt == '0);

    // one extra bit on the far side catches the last bit shifted out
    assign lsl_ext = {1'b0, shift_val} << amt;
    assign lsr_ext = {shift_val, 1'b0} >> amt;
    assign asr_ext = $signed({shift_val, 1'b0}) >>> amt;
    assign ror_ext = {i_dest_value, i_dest_value} >> cnt[IMM_W-1:0];

    always_comb begin
        o_res.result   = '0;
        o_res.write_en = 1'b1;
        o_res.update   = 1'b1;
        o_res.carry    = i_carry;
        unique case (i_opcode)
            OP_AND: o_res.result = i_dest_value & i_source_value;
            OP_BIC: o_res.result = i_dest_value & ~i_source_value;
            OP_EOR: o_res.result = i_dest_value ^ i_source_value;
            OP_ORR: o_res.result = i_dest_value | i_source_value;
            OP_MVN: o_res.result = ~i_source_value;
            OP_ASR_IMM, OP_ASR_REG: begin
                o_res.result = asr_ext[DATA_W:1];
                if (!keep_c) begin
                    o_res.carry = asr_ext[0];
                end
            end
            OP_LSL_IMM, OP_LSL_REG: begin
                o_res.result = lsl_ext[DATA_W-1:0];
                if (!keep_c) begin
                    o_res.carry = lsl_ext[DATA_W];
                end
            end
            OP_LSR_IMM, OP_LSR_REG: begin
                o_res.result = lsr_ext[DATA_W:1];
                if (!keep_c) begin
                    o_res.carry = lsr_ext[0];
                end
            end
            OP_ROR_REG: begin
                o_res.result = ror_ext[DATA_W-1:0];
                if (cnt == '0) begin
                    o_res.write_en = 1'b0;
                end else begin
                    o_res.carry = ror_ext[DATA_W-1];
                end
            end
            default: begin
                o_res.write_en = 1'b0;
                o_res.update   = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/thumb_logic_shift_alu.sv */
// stages: input register, then result register; a beat taken on the input is registered
// in both before the result beat can be taken
// throughput: one beat per cycle, sustained while the output is not stalled by i_ready; the
// flag update is combinational between the input register and the result register
// reset (i_rst_n low, synchronous): both stages empty, n, z and c flag register cleared
module thumb_logic_shift_alu
    import tlsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [DATA_W-1:0]   i_dest_value,
    input  logic [DATA_W-1:0]   i_source_value,
    input  logic [IMM_W-1:0]    i_shift_imm,
    input  logic [INDEX_W-1:0]  i_dest_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DATA_W-1:0]   o_result_value,
    output logic [INDEX_W-1:0]  o_write_index,
    output logic                o_write_enable,
    output logic                o_negative_flag,
    output logic                o_zero_flag,
    output logic                o_carry_flag
);

    logic                r_in_valid;
    logic [OPCODE_W-1:0] r_opcode;
    logic [DATA_W-1:0]   r_dest_value;
    logic [DATA_W-1:0]   r_source_value;
    logic [IMM_W-1:0]    r_shift_imm;
    logic [INDEX_W-1:0]  r_dest_index;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_result;
    logic [INDEX_W-1:0]  r_index;
    logic                r_write_en;
    t_flags              r_out_flags;

    t_flags              r_flags;
    t_flags              n_flags;
    t_exec_res           exec_res;
    logic                advance;
    logic                in_take;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    tlsa_exec u_exec (
        .i_opcode       (r_opcode),
        .i_dest_value   (r_dest_value),
        .i_source_value (r_source_value),
        .i_shift_imm    (r_shift_imm),
        .i_carry        (r_flags.flag_c),
        .o_res          (exec_res)
    );

    // undefined opcodes hold and report the old flags
    always_comb begin
        n_flags = r_flags;
        if (exec_res.update) begin
            n_flags.flag_n = exec_res.result[DATA_W-1];
            n_flags.flag_z = (exec_res.result == '0);
            n_flags.flag_c = exec_res.carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode       <= i_opcode;
            r_dest_value   <= i_dest_value;
            r_source_value <= i_source_value;
            r_shift_imm    <= i_shift_imm;
            r_dest_index   <= i_dest_index;
        end
        if (advance) begin
            r_result    <= exec_res.result;
            r_index     <= r_dest_index;
            r_write_en  <= exec_res.write_en;
            r_out_flags <= n_flags;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_value  = r_result;
    assign o_write_index   = r_index;
    assign o_write_enable  = r_write_en;
    assign o_negative_flag = r_out_flags.flag_n;
    assign o_zero_flag     = r_out_flags.flag_z;
    assign o_carry_flag    = r_out_flags.flag_c;

    // the beat on the output always shows the live flag state
    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_out_flags == r_flags))
        else $error("output flags differ from flag register");

    // a zero result can never be negative, held flags included
    a_nz_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags.flag_n && r_flags.flag_z))
        else $error("n and z set together");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && o_valid && !i_ready))
        else $error("input stalled while pipeline can move");

    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("advanced item missing from output");

    a_no_write_on_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !exec_res.update) |=> (!o_write_enable && o_result_value == '0))
        else $error("undefined opcode produced a write");

endmodule

/* tb/tb_thumb_logic_shift_alu.sv */
`timescale 1ns / 100ps

module tb_thumb_logic_shift_alu;
    import tlsa_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 9;
    localparam int RANDOM_PER_PHASE = 370;
    localparam int HOLD_CYCLES      = 150;
    localparam int HOLD_BEATS       = 60;
    localparam int PAUSE_BEATS      = 20;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 200000;

    // opcodes past the last shift decode as no operation
    localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 4'd15;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   dest_value;
        logic [DATA_W-1:0]   source_value;
        logic [IMM_W-1:0]    shift_imm;
        logic [INDEX_W-1:0]  dest_index;
    } t_alu_beat;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
        logic               wen;
        logic               n;
        logic               z;
        logic               c;
    } t_alu_result;

    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic [OPCODE_W-1:0] i_opcode       = '0;
    logic [DATA_W-1:0]   i_dest_value   = '0;
    logic [DATA_W-1:0]   i_source_value = '0;
    logic [IMM_W-1:0]    i_shift_imm    = '0;
    logic [INDEX_W-1:0]  i_dest_index   = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [DATA_W-1:0]   o_result_value;
    logic [INDEX_W-1:0]  o_write_index;
    logic                o_write_enable;
    logic                o_negative_flag;
    logic                o_zero_flag;
    logic                o_carry_flag;

    t_alu_result pending_results[$];
    logic        model_n = 1'b0;
    logic        model_z = 1'b0;
    logic        model_c = 1'b0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    logic        holding      = 1'b0;
    event        hold_trig;

    thumb_logic_shift_alu i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_dest_value    (i_dest_value),
        .i_source_value  (i_source_value),
        .i_shift_imm     (i_shift_imm),
        .i_dest_index    (i_dest_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_value  (o_result_value),
        .o_write_index   (o_write_index),
        .o_write_enable  (o_write_enable),
        .o_negative_flag (o_negative_flag),
        .o_zero_flag     (o_zero_flag),
        .o_carry_flag    (o_carry_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // executes one instruction against the tracked flags
    function automatic t_alu_result exec_logic_shift(input t_alu_beat b);
        t_alu_result       r;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] dv;
        logic [DATA_W-1:0] sv;
        logic [7:0]        cnt;
        logic [4:0]        rot;
        logic              c;
        logic              we;
        logic              upd;
        dv  = b.dest_value;
        sv  = b.source_value;
        cnt = sv[7:0];
        rot = cnt[4:0];
        res = '0;
        c   = model_c;
        we  = 1'b1;
        upd = 1'b1;
        case (b.opcode)
            OP_AND: res = dv & sv;
            OP_BIC: res = dv & ~sv;
            OP_EOR: res = dv ^ sv;
            OP_ORR: res = dv | sv;
            OP_MVN: res = ~sv;
            OP_ASR_IMM: begin
                if (b.shift_imm == '0) begin
                    res = {DATA_W{sv[31]}};
                    c   = sv[31];
                end else begin
                    res = $signed(sv) >>> b.shift_imm;
                    c   = sv[b.shift_imm - 1];
                end
            end
            OP_ASR_REG: begin
                if (cnt == 8'd0) begin
                    res = dv;
                end else if (cnt < 8'd32) begin
                    res = $signed(dv) >>> cnt;
                    c   = dv[cnt - 1];
                end else begin
                    res = {DATA_W{dv[31]}};
                    c   = dv[31];
                end
            end
            OP_LSL_IMM: begin
                if (b.shift_imm == '0) begin
                    res = sv;
                end else begin
                    res = sv << b.shift_imm;
                    c   = sv[32 - b.shift_imm];
                end
            end
            OP_LSR_IMM: begin
                if (b.shift_imm == '0) begin
                    res = '0;
                    c   = sv[31];
                end else begin
                    res = sv >> b.shift_imm;
                    c   = sv[b.shift_imm - 1];
                end
            end
            OP_LSL_REG: begin
                if (cnt == 8'd0) begin
                    res = dv;
                end else if (cnt < 8'd32) begin
                    res = dv << cnt;
                    c   = dv[32 - cnt];
                end else begin
                    res = '0;
                    c   = (cnt == 8'd32) ? dv[0] : 1'b0;
                end
            end
            OP_LSR_REG: begin
                if (cnt == 8'd0) begin
                    res = dv;
                end else if (cnt < 8'd32) begin
                    res = dv >> cnt;
                    c   = dv[cnt - 1];
                end else begin
                    res = '0;
                    c   = (cnt == 8'd32) ? dv[31] : 1'b0;
                end
            end
            OP_ROR_REG: begin
                if (cnt == 8'd0) begin
                    res = dv;
                    we  = 1'b0;
                end else begin
                    res = (rot == 5'd0) ? dv : ((dv >> rot) | (dv << (32 - rot)));
                    c   = res[31];
                end
            end
            default: begin
                upd = 1'b0;
                we  = 1'b0;
                res = '0;
            end
        endcase
        if (upd) begin
            model_n = res[31];
            model_z = (res == '0);
            model_c = c;
        end
        r.value = res;
        r.index = b.dest_index;
        r.wen   = we;
        r.n     = model_n;
        r.z     = model_z;
        r.c     = model_c;
        return r;
    endfunction

    // results are checked before the same edge's input beat is predicted
    always @(posedge i_clk) begin
        t_alu_result exp_r;
        t_alu_beat   in_b;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no instruction outstanding");
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_result_value !== exp_r.value) begin
                    $error("result_value expected %h actual %h", exp_r.value, o_result_value);
                    mismatches++;
                end
                if (o_write_index !== exp_r.index) begin
                    $error("write_index expected %0d actual %0d", exp_r.index, o_write_index);
                    mismatches++;
                end
                if (o_write_enable !== exp_r.wen) begin
                    $error("write_enable expected %b actual %b", exp_r.wen, o_write_enable);
                    mismatches++;
                end
                if (o_negative_flag !== exp_r.n) begin
                    $error("negative_flag expected %b actual %b", exp_r.n, o_negative_flag);
                    mismatches++;
                end
                if (o_zero_flag !== exp_r.z) begin
                    $error("zero_flag expected %b actual %b", exp_r.z, o_zero_flag);
                    mismatches++;
                end
                if (o_carry_flag !== exp_r.c) begin
                    $error("carry_flag expected %b actual %b", exp_r.c, o_carry_flag);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            in_b = '{i_opcode, i_dest_value, i_source_value, i_shift_imm, i_dest_index};
            pending_results.push_back(exec_logic_shift(in_b));
        end
    end

    always @(posedge i_clk) begin
        if (holding) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin
        forever begin
            @(hold_trig);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            holding <= 1'b0;
        end
    end

    function automatic t_alu_beat make_beat(input logic [OPCODE_W-1:0] op,
                                            input logic [DATA_W-1:0] dv,
                                            input logic [DATA_W-1:0] sv,
                                            input logic [IMM_W-1:0] imm,
                                            input logic [INDEX_W-1:0] idx);
        t_alu_beat b;
        b = '{op, dv, sv, imm, idx};
        return b;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            2:       w = 32'h8000_0000;
            3:       w = 32'h7FFF_FFFF;
            4:       w = 32'h0000_0001;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    function automatic t_alu_beat random_beat();
        t_alu_beat         b;
        logic [DATA_W-1:0] raw;
        logic [7:0]        cnt;
        raw = $urandom();
        if ($urandom_range(0, 99) < 6) begin
            b.opcode = OPCODE_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end else begin
            b.opcode = OPCODE_W'($urandom_range(OP_AND, OP_ROR_REG));
        end
        b.dest_value = pick_word();
        b.shift_imm  = ($urandom_range(0, 3) == 0) ? '0 : IMM_W'($urandom_range(0, 31));
        b.dest_index = INDEX_W'($urandom_range(0, 7));
        if (b.opcode inside {OP_ASR_REG, OP_LSL_REG, OP_LSR_REG, OP_ROR_REG}) begin
            // steer the count byte onto zero, 32, past 32 and whole rotations
            case ($urandom_range(0, 7))
                0:       cnt = 8'd0;
                1:       cnt = 8'd32;
                2:       cnt = 8'($urandom_range(33, 255));
                3:       cnt = 8'hFF;
                4:       cnt = {3'($urandom_range(1, 7)), 5'd0};
                default: cnt = 8'($urandom_range(1, 31));
            endcase
            b.source_value = {raw[31:8], cnt};
        end else begin
            b.source_value = pick_word();
        end
        return b;
    endfunction

    task automatic send_beat(input t_alu_beat b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= b.opcode;
        i_dest_value   <= b.dest_value;
        i_source_value <= b.source_value;
        i_shift_imm    <= b.shift_imm;
        i_dest_index   <= b.dest_index;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        send_beat(make_beat(OP_AND, '1, '1, 5'd31, 3'd7));
        send_beat(make_beat(OP_AND, '0, '1, 5'd0, 3'd0));
        // leave carry set so the logical ops below show it held
        send_beat(make_beat(OP_LSL_IMM, '0, 32'h8000_0001, 5'd1, 3'd1));
        send_beat(make_beat(OP_BIC, '1, 32'h0F0F_0F0F, 5'd3, 3'd2));
        send_beat(make_beat(OP_EOR, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 5'd0, 3'd3));
        send_beat(make_beat(OP_ORR, 32'h8000_0000, 32'h0000_0001, 5'd0, 3'd4));
        send_beat(make_beat(OP_MVN, '1, '0, 5'd0, 3'd5));
        send_beat(make_beat(OP_ASR_IMM, '0, 32'h8000_0000, 5'd0, 3'd6));
        send_beat(make_beat(OP_ASR_IMM, '0, 32'h7FFF_FFFF, 5'd0, 3'd7));
        send_beat(make_beat(OP_ASR_IMM, '0, 32'h8000_0000, 5'd31, 3'd0));
        send_beat(make_beat(OP_LSR_IMM, '0, '1, 5'd0, 3'd1));
        send_beat(make_beat(OP_LSR_IMM, '0, 32'h0000_0001, 5'd1, 3'd2));
        send_beat(make_beat(OP_LSL_IMM, '0, 32'h1234_5678, 5'd0, 3'd3));
        send_beat(make_beat(OP_LSL_IMM, '0, 32'h0000_0003, 5'd31, 3'd4));
        send_beat(make_beat(OP_ASR_REG, 32'h8000_0000, 32'hFFFF_FF00, 5'd5, 3'd5));
        send_beat(make_beat(OP_ASR_REG, 32'h8000_0000, 32'h0000_0020, 5'd0, 3'd6));
        send_beat(make_beat(OP_ASR_REG, 32'h7FFF_FFFF, 32'h0000_00C8, 5'd0, 3'd7));
        send_beat(make_beat(OP_LSL_REG, 32'h0000_0001, 32'h0000_0020, 5'd0, 3'd0));
        send_beat(make_beat(OP_LSL_REG, '1, 32'h0000_0021, 5'd0, 3'd1));
        send_beat(make_beat(OP_LSR_REG, 32'h8000_0000, 32'h0000_0020, 5'd0, 3'd2));
        send_beat(make_beat(OP_LSR_REG, '1, 32'h0000_00FF, 5'd0, 3'd3));
        send_beat(make_beat(OP_LSR_REG, 32'hDEAD_BEEF, 32'hFFFF_FF00, 5'd0, 3'd4));
        send_beat(make_beat(OP_ROR_REG, 32'h8000_0000, 32'h0000_0000, 5'd0, 3'd5));
        send_beat(make_beat(OP_ROR_REG, 32'h8000_0000, 32'h0000_0020, 5'd0, 3'd6));
        send_beat(make_beat(OP_ROR_REG, 32'h0000_0001, 32'h0000_0040, 5'd0, 3'd7));
        send_beat(make_beat(OP_ROR_REG, 32'h0000_000F, 32'h0000_0004, 5'd0, 3'd0));
        send_beat(make_beat(OP_UNDEF_LO, '1, '1, 5'd31, 3'd7));
        send_beat(make_beat(OP_UNDEF_HI, '0, '0, 5'd0, 3'd0));
    endtask

    task automatic test_random_traffic();
        int tx_pcts[4];
        int rx_pcts[4];
        tx_pcts = '{0, 69, 0, 37};
        rx_pcts = '{0, 0, 69, 37};
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            repeat (RANDOM_PER_PHASE) send_beat(random_beat());
        end
    endtask

    // receiver holds off while the sender keeps pushing, so the pipe backs up
    task automatic test_output_holdoff();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        -> hold_trig;
        repeat (HOLD_BEATS) send_beat(random_beat());
    endtask

    task automatic test_sender_pause();
        tx_idle_pct  = 37;
        rx_stall_pct = 37;
        repeat (PAUSE_BEATS) send_beat(random_beat());
        wait_for_drain();
        repeat (PAUSE_BEATS) send_beat(random_beat());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic();
        test_output_holdoff();
        test_sender_pause();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
